[rtl/pah_pkg.sv]
// Shared constants and controller/datapath interface types for the page heat table.
// No dependencies; imported by every module of the block.
package pah_pkg;

   localparam int TABLE_ENTRIES = 1024;
   localparam int COUNT_BITS    = 16;
   localparam int PAGE_W        = 36;
   localparam int CAP_W         = 10;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);
   localparam int ENTRY_W       = $clog2(TABLE_ENTRIES + 1);
   localparam int MODE_W        = 2;

   localparam logic [CAP_W-1:0]      HEAT_CAP_RESET = CAP_W'(200);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX      = {COUNT_BITS{1'b1}};

   localparam logic [MODE_W-1:0] MODE_RECORD = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

   typedef struct packed {
      logic load;
      logic scan;
      logic finish;
   } ctl_cmd_type;

   typedef struct packed {
      logic scan_done;
   } dp_status_type;

endpackage

[rtl/page_access_heat_table.sv]
// Top level of the page heat table: controller plus datapath.
// Depends on pah_pkg, pah_ctrl and pah_dp.
//
// An item is taken when start is high and busy low. A record or query scans the used
// entries one per cycle through a single read port of the tag and count memories; a clear
// or unused mode skips the scan and goes straight to finish.
// The result shows for one cycle with rsp_valid and cannot be held off; the next item may
// be started in that same cycle. The memories need no clearing after reset.
module page_access_heat_table (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [pah_pkg::MODE_W-1:0]      req_mode,
   input  logic [pah_pkg::PAGE_W-1:0]      req_page_number,
   input  logic [pah_pkg::CAP_W-1:0]       req_bin,
   input  logic                            csr_write_en,
   input  logic [pah_pkg::CAP_W-1:0]       csr_write_data,
   output logic                            rsp_valid,
   output logic                            rsp_was_present,
   output logic                            rsp_dropped,
   output logic [pah_pkg::ENTRY_W-1:0]     rsp_entry_count,
   output logic [pah_pkg::ENTRY_W-1:0]     rsp_bin_count,
   output logic [pah_pkg::COUNT_BITS-1:0]  rsp_low_heat,
   output logic [pah_pkg::COUNT_BITS-1:0]  rsp_high_heat,
   output logic [pah_pkg::CAP_W-1:0]       rsp_top_bin,
   output logic                            rsp_empty_res
);
   import pah_pkg::*;

   ctl_cmd_type   cmd;
   dp_status_type status;

   pah_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_mode  (req_mode),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   pah_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_mode        (req_mode),
      .req_page_number (req_page_number),
      .req_bin         (req_bin),
      .csr_write_en    (csr_write_en),
      .csr_write_data  (csr_write_data),
      .rsp_was_present (rsp_was_present),
      .rsp_dropped     (rsp_dropped),
      .rsp_entry_count (rsp_entry_count),
      .rsp_bin_count   (rsp_bin_count),
      .rsp_low_heat    (rsp_low_heat),
      .rsp_high_heat   (rsp_high_heat),
      .rsp_top_bin     (rsp_top_bin),
      .rsp_empty_res   (rsp_empty_res)
   );

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("item accepted but block not busy");

   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without an item in flight");

   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_dropped) |-> (rsp_entry_count == ENTRY_W'(TABLE_ENTRIES)))
      else $error("item dropped with table not full");

   a_hit_or_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_was_present && rsp_dropped))
      else $error("hit and drop flagged together");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_empty_res == (rsp_entry_count == '0)))
      else $error("empty flag disagrees with entry count");

endmodule

[rtl/pah_ctrl.sv]
// Sequencer for the page heat table: load, table scan, finish.
// Depends on pah_pkg.
module pah_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [pah_pkg::MODE_W-1:0]  req_mode,
   input  pah_pkg::dp_status_type      status,
   output pah_pkg::ctl_cmd_type        cmd,
   output logic                        busy,
   output logic                        rsp_valid
);
   import pah_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FIN
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, rsp_valid_ff;

   always_comb begin
      state_in   = state_ff;
      cmd.load   = 1'b0;
      cmd.scan   = 1'b0;
      cmd.finish = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               if (req_mode == MODE_RECORD || req_mode == MODE_QUERY)
                  state_in = ST_SCAN;
               else
                  state_in = ST_FIN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_done)
               state_in = ST_FIN;
         end
         ST_FIN: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= (state_in != ST_IDLE);
         rsp_valid_ff <= (state_ff == ST_FIN);
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

[rtl/pah_dp.sv]
// Datapath: tag and count memories, scan pointer, statistics and result registers.
// Depends on pah_pkg.
module pah_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  pah_pkg::ctl_cmd_type            cmd,
   output pah_pkg::dp_status_type          status,
   input  logic [pah_pkg::MODE_W-1:0]      req_mode,
   input  logic [pah_pkg::PAGE_W-1:0]      req_page_number,
   input  logic [pah_pkg::CAP_W-1:0]       req_bin,
   input  logic                            csr_write_en,
   input  logic [pah_pkg::CAP_W-1:0]       csr_write_data,
   output logic                            rsp_was_present,
   output logic                            rsp_dropped,
   output logic [pah_pkg::ENTRY_W-1:0]     rsp_entry_count,
   output logic [pah_pkg::ENTRY_W-1:0]     rsp_bin_count,
   output logic [pah_pkg::COUNT_BITS-1:0]  rsp_low_heat,
   output logic [pah_pkg::COUNT_BITS-1:0]  rsp_high_heat,
   output logic [pah_pkg::CAP_W-1:0]       rsp_top_bin,
   output logic                            rsp_empty_res
);
   import pah_pkg::*;

   logic [PAGE_W-1:0]     tag_mem [TABLE_ENTRIES];
   logic [COUNT_BITS-1:0] cnt_mem [TABLE_ENTRIES];

   logic [CAP_W-1:0]      cap_ff;
   logic [ENTRY_W-1:0]    used_ff, used_in;
   logic [ENTRY_W-1:0]    addr_ff;
   logic                  rd_vld_ff, hit_ff;
   logic [IDX_W-1:0]      rd_idx_ff;
   logic [MODE_W-1:0]     mode_ff;
   logic [PAGE_W-1:0]     page_ff;
   logic [CAP_W-1:0]      bin_ff;
   logic [PAGE_W-1:0]     tag_q_ff;
   logic [COUNT_BITS-1:0] cnt_q_ff, cnt_inc;
   logic [COUNT_BITS-1:0] min_ff, max_ff;
   logic [ENTRY_W-1:0]    binc_ff;

   logic                  is_rec, is_qry, is_clr;
   logic                  match, issue_ok, issue, append, bin_hit;
   logic                  cnt_we;
   logic [IDX_W-1:0]      cnt_waddr;
   logic [COUNT_BITS-1:0] cnt_wdata;
   logic [CAP_W-1:0]      top_bin;

   assign is_rec = (mode_ff == MODE_RECORD);
   assign is_qry = (mode_ff == MODE_QUERY);
   assign is_clr = (mode_ff == MODE_CLEAR);

   assign match    = rd_vld_ff && !hit_ff && is_rec && (tag_q_ff == page_ff);
   assign issue_ok = (addr_ff < used_ff) && !hit_ff && !match;
   assign issue    = cmd.scan && issue_ok;
   assign status.scan_done = !issue_ok && !rd_vld_ff;

   assign cnt_inc = (cnt_q_ff == COUNT_MAX) ? cnt_q_ff : cnt_q_ff + COUNT_BITS'(1);
   assign append  = cmd.finish && is_rec && !hit_ff && (used_ff < ENTRY_W'(TABLE_ENTRIES));

   // saturating bump on a hit during the scan, fresh count on append
   always_comb begin
      cnt_we    = 1'b0;
      cnt_waddr = rd_idx_ff;
      cnt_wdata = cnt_inc;
      if (match) begin
         cnt_we = 1'b1;
      end else if (append) begin
         cnt_we    = 1'b1;
         cnt_waddr = used_ff[IDX_W-1:0];
         cnt_wdata = COUNT_BITS'(1);
      end
   end

   always_comb begin
      if (bin_ff < cap_ff)
         bin_hit = (cnt_q_ff == COUNT_BITS'(bin_ff));
      else if (bin_ff == cap_ff)
         bin_hit = (cnt_q_ff >= COUNT_BITS'(cap_ff));
      else
         bin_hit = 1'b0;
   end

   always_comb begin
      used_in = used_ff;
      if (cmd.finish && is_clr)
         used_in = '0;
      else if (append)
         used_in = used_ff + ENTRY_W'(1);
   end

   assign top_bin = (max_ff < COUNT_BITS'(cap_ff)) ? max_ff[CAP_W-1:0] : cap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff    <= HEAT_CAP_RESET;
         used_ff   <= '0;
         addr_ff   <= '0;
         rd_vld_ff <= 1'b0;
         hit_ff    <= 1'b0;
      end else begin
         if (csr_write_en)
            cap_ff <= csr_write_data;
         used_ff   <= used_in;
         rd_vld_ff <= issue;
         if (cmd.load) begin
            addr_ff <= '0;
            hit_ff  <= 1'b0;
         end else begin
            if (issue)
               addr_ff <= addr_ff + ENTRY_W'(1);
            if (match)
               hit_ff <= 1'b1;
         end
      end
   end

   // memories
   always_ff @(posedge clock) begin
      if (issue) begin
         tag_q_ff <= tag_mem[addr_ff[IDX_W-1:0]];
         cnt_q_ff <= cnt_mem[addr_ff[IDX_W-1:0]];
      end
      if (append)
         tag_mem[used_ff[IDX_W-1:0]] <= page_ff;
      if (cnt_we)
         cnt_mem[cnt_waddr] <= cnt_wdata;
   end

   always_ff @(posedge clock) begin
      if (issue)
         rd_idx_ff <= addr_ff[IDX_W-1:0];
      if (cmd.load) begin
         mode_ff <= req_mode;
         page_ff <= req_page_number;
         bin_ff  <= req_bin;
         min_ff  <= COUNT_MAX;
         max_ff  <= '0;
         binc_ff <= '0;
      end else if (rd_vld_ff && is_qry) begin
         if (cnt_q_ff < min_ff)
            min_ff <= cnt_q_ff;
         if (cnt_q_ff > max_ff)
            max_ff <= cnt_q_ff;
         if (bin_hit)
            binc_ff <= binc_ff + ENTRY_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_was_present <= is_rec && hit_ff;
         rsp_dropped     <= is_rec && !hit_ff && (used_ff >= ENTRY_W'(TABLE_ENTRIES));
         rsp_entry_count <= used_in;
         rsp_empty_res   <= (used_in == '0);
         if (is_qry && used_ff != '0) begin
            rsp_bin_count <= binc_ff;
            rsp_low_heat  <= min_ff;
            rsp_high_heat <= max_ff;
            rsp_top_bin   <= top_bin;
         end else begin
            rsp_bin_count <= '0;
            rsp_low_heat  <= '0;
            rsp_high_heat <= '0;
            rsp_top_bin   <= '0;
         end
      end
   end

endmodule
